// File: rtl/fts_pkg.sv
// shared types and constants for the frame type statistics block
package fts_pkg;

  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned HIST_W     = 16;
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned RATE_SCALE = 1000;
  localparam int unsigned SCALE_W    = 10;
  localparam int unsigned DIVIDEND_W = COUNT_W + SCALE_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd1000;
  localparam logic [HIST_W-1:0]   PEAK_FLOOR    = 16'd1;
  localparam logic [LEN_W-1:0]    MIN_FRAME_LEN = 12'd2;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  // frame control type field, bits 3:2
  localparam logic [1:0] FTYPE_MGMT = 2'd0;
  localparam logic [1:0] FTYPE_DATA = 2'd2;

  // management subtypes, bits 7:4
  localparam logic [3:0] SUB_PROBE_REQ  = 4'h4;
  localparam logic [3:0] SUB_PROBE_RESP = 4'h5;
  localparam logic [3:0] SUB_BEACON     = 4'h8;
  localparam logic [3:0] SUB_DISASSOC   = 4'hA;
  localparam logic [3:0] SUB_DEAUTH     = 4'hC;

  typedef struct packed {
    logic              clear;
    logic              push;
    logic [HIST_W-1:0] total;
  } ring_cmd_t;

  typedef struct packed {
    logic              done;
    logic [HIST_W-1:0] peak;
  } ring_stat_t;

endpackage

// File: rtl/fts_ram.sv
// generic simple dual-port ram with registered read
module fts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/fts_divider.sv
// iterative restoring divider for count * 1000 / period, saturated to 32 bits
module fts_divider import fts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [COUNT_W-1:0]  count_i,
  input  logic [PERIOD_W-1:0] period_i,
  output logic                done_o,
  output logic [COUNT_W-1:0]  quot_o
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [PERIOD_W-1:0]   rem_q, rem_d;
  logic [PERIOD_W-1:0]   dsr_q, dsr_d;
  logic [PERIOD_W:0]     rem_sh;
  logic [PERIOD_W:0]     rem_sub;
  logic                  fits;

  assign rem_sh  = {rem_q, dvd_q[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign fits    = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      // product is at most 42 bits, registered before the first step
      dvd_d  = DIVIDEND_W'(count_i) * DIVIDEND_W'(RATE_SCALE);
      rem_d  = '0;
      dsr_d  = period_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // quotient bits shift in at the bottom as dividend bits leave the top
      dvd_d  = {dvd_q[DIVIDEND_W-2:0], fits};
      rem_d  = fits ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = (|dvd_q[DIVIDEND_W-1:COUNT_W]) ? '1 : dvd_q[COUNT_W-1:0];

endmodule

// File: rtl/fts_ring.sv
// history ring of window totals with a peak rescan over the filled entries
module fts_ring import fts_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ring_cmd_t  cmd_i,
  output ring_stat_t stat_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic [AW-1:0]     idx_q, idx_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [FW-1:0]     scan_q, scan_d;
  logic              scanning_q, scanning_d;
  logic              rd_pend_q, rd_pend_d;
  logic              done_q, done_d;
  logic [HIST_W-1:0] peak_q, peak_d;
  logic              rd_issue;
  logic [HIST_W-1:0] rdata;

  // entries at or beyond the fill count were never written since start and are not read
  assign rd_issue = scanning_q && (scan_q < fill_q);

  fts_ram #(
    .WIDTH (HIST_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (idx_q),
    .wdata_i (cmd_i.total),
    .re_i    (rd_issue),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    idx_d      = idx_q;
    fill_d     = fill_q;
    scan_d     = scan_q;
    scanning_d = scanning_q;
    rd_pend_d  = 1'b0;
    done_d     = 1'b0;
    peak_d     = peak_q;
    if (cmd_i.clear) begin
      idx_d      = '0;
      fill_d     = '0;
      scanning_d = 1'b0;
      peak_d     = PEAK_FLOOR;
    end else if (cmd_i.push) begin
      idx_d      = (idx_q == AW'(DEPTH - 1)) ? '0 : idx_q + AW'(1);
      fill_d     = (fill_q == FW'(DEPTH)) ? fill_q : fill_q + FW'(1);
      scan_d     = '0;
      scanning_d = 1'b1;
      peak_d     = PEAK_FLOOR;
    end else if (scanning_q) begin
      rd_pend_d = rd_issue;
      if (rd_issue) begin
        scan_d = scan_q + FW'(1);
      end
      if (rd_pend_q && (rdata > peak_q)) begin
        peak_d = rdata;
      end
      if (!rd_issue && !rd_pend_q) begin
        scanning_d = 1'b0;
        done_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      fill_q     <= '0;
      scan_q     <= '0;
      scanning_q <= 1'b0;
      rd_pend_q  <= 1'b0;
      done_q     <= 1'b0;
      peak_q     <= PEAK_FLOOR;
    end else begin
      idx_q      <= idx_d;
      fill_q     <= fill_d;
      scan_q     <= scan_d;
      scanning_q <= scanning_d;
      rd_pend_q  <= rd_pend_d;
      done_q     <= done_d;
      peak_q     <= peak_d;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.peak = peak_q;

`ifndef SYNTHESIS
  a_push_not_scanning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !scanning_q)
    else $error("ring push while a rescan is running");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(DEPTH))
    else $error("ring fill count beyond depth");

  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(scanning_q) && !scanning_q && peak_q != '0))
    else $error("ring done without a finished rescan");
`endif

endmodule

// File: rtl/wlan_frame_type_statistics.sv
// frame type statistics: window counters, rate division, history ring and result register
// frame, start and stop items never hold off input and may follow back to back.
// a tick that closes a window holds off input until the result of that window is loaded,
//   set by the shared serial divider (42 steps per rate, four rates) and the ring rescan.
// the result appears once the rates and the rescan are done; a waiting result only stalls the next close.
// reset is asynchronous and takes effect at once; the ring uses a fill count, no clearing pass.
module wlan_frame_type_statistics import fts_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PERIOD_W-1:0] cfg_sample_period_ms_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          frame_control_byte_i,
  input  logic [LEN_W-1:0]    frame_length_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [COUNT_W-1:0]  rate_total_o,
  output logic [COUNT_W-1:0]  rate_beacon_o,
  output logic [COUNT_W-1:0]  rate_data_o,
  output logic [COUNT_W-1:0]  rate_deauth_o,
  output logic [COUNT_W-1:0]  window_probe_o,
  output logic [COUNT_W-1:0]  window_mgmt_o,
  output logic [HIST_W-1:0]   history_max_o,
  output logic [COUNT_W-1:0]  all_time_total_o,
  output logic [COUNT_W-1:0]  all_time_deauth_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_JOIN = 2'd2;

  localparam logic [1:0] LANE_TOTAL  = 2'd0;
  localparam logic [1:0] LANE_BEACON = 2'd1;
  localparam logic [1:0] LANE_DATA   = 2'd2;
  localparam logic [1:0] LANE_DEAUTH = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic                running_q, running_d;
  logic [PERIOD_W-1:0] elapsed_q, elapsed_d;
  logic [COUNT_W-1:0]  cnt_total_q, cnt_total_d;
  logic [COUNT_W-1:0]  cnt_beacon_q, cnt_beacon_d;
  logic [COUNT_W-1:0]  cnt_data_q, cnt_data_d;
  logic [COUNT_W-1:0]  cnt_deauth_q, cnt_deauth_d;
  logic [COUNT_W-1:0]  cnt_probe_q, cnt_probe_d;
  logic [COUNT_W-1:0]  cnt_mgmt_q, cnt_mgmt_d;
  logic [COUNT_W-1:0]  sum_total_q, sum_total_d;
  logic [COUNT_W-1:0]  sum_deauth_q, sum_deauth_d;
  logic [1:0]          lane_q, lane_d;
  logic                ring_done_q, ring_done_d;
  logic [COUNT_W-1:0]  rate_q [4];
  logic [COUNT_W-1:0]  rate_d [4];
  logic                out_valid_q, out_valid_d;

  logic [COUNT_W-1:0]  o_rate_total_q, o_rate_beacon_q, o_rate_data_q, o_rate_deauth_q;
  logic [COUNT_W-1:0]  o_probe_q, o_mgmt_q, o_sum_total_q, o_sum_deauth_q;
  logic [HIST_W-1:0]   o_peak_q;
  logic                load_out;

  logic                in_fire;
  op_e                 op;
  logic [1:0]          ftype;
  logic [3:0]          fsub;
  logic [PERIOD_W-1:0] period_eff;
  logic [PERIOD_W-1:0] elapsed_inc;
  logic                close_now;
  logic                out_free;
  logic [1:0]          start_lane;
  logic                div_start;
  logic [COUNT_W-1:0]  div_count;
  logic                div_done;
  logic [COUNT_W-1:0]  div_quot;
  ring_cmd_t           ring_cmd;
  ring_stat_t          ring_stat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign op          = op_e'(operation_i);
  assign ftype       = frame_control_byte_i[3:2];
  assign fsub        = frame_control_byte_i[7:4];
  assign period_eff  = (period_q == '0) ? PERIOD_W'(1) : period_q;
  // window timer saturates at its top value
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + PERIOD_W'(1);
  assign close_now   = in_fire && (op == OP_TICK) && running_q && (elapsed_inc >= period_eff);
  assign out_free    = !out_valid_q || out_ready_i;
  assign start_lane  = (state_q == S_IDLE) ? LANE_TOTAL : lane_q + 2'd1;

  always_comb begin
    case (start_lane)
      LANE_TOTAL:  div_count = cnt_total_q;
      LANE_BEACON: div_count = cnt_beacon_q;
      LANE_DATA:   div_count = cnt_data_q;
      default:     div_count = cnt_deauth_q;
    endcase
  end

  fts_divider u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .count_i  (div_count),
    .period_i (period_eff),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  fts_ring #(
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ring_cmd),
    .stat_o (ring_stat)
  );

  always_comb begin
    state_d      = state_q;
    period_d     = period_q;
    running_d    = running_q;
    elapsed_d    = elapsed_q;
    cnt_total_d  = cnt_total_q;
    cnt_beacon_d = cnt_beacon_q;
    cnt_data_d   = cnt_data_q;
    cnt_deauth_d = cnt_deauth_q;
    cnt_probe_d  = cnt_probe_q;
    cnt_mgmt_d   = cnt_mgmt_q;
    sum_total_d  = sum_total_q;
    sum_deauth_d = sum_deauth_q;
    lane_d       = lane_q;
    ring_done_d  = ring_done_q || ring_stat.done;
    rate_d       = rate_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    load_out     = 1'b0;
    div_start    = 1'b0;
    ring_cmd       = '0;
    ring_cmd.total = cnt_total_q[HIST_W-1:0];

    if (cfg_valid_i && cfg_ready_o) begin
      period_d = cfg_sample_period_ms_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_FRAME: begin
              if (running_q && (frame_length_i >= MIN_FRAME_LEN)) begin
                cnt_total_d = cnt_total_q + COUNT_W'(1);
                if (ftype == FTYPE_MGMT) begin
                  cnt_mgmt_d = cnt_mgmt_q + COUNT_W'(1);
                  if (fsub == SUB_BEACON) begin
                    cnt_beacon_d = cnt_beacon_q + COUNT_W'(1);
                  end else if ((fsub == SUB_PROBE_REQ) || (fsub == SUB_PROBE_RESP)) begin
                    cnt_probe_d = cnt_probe_q + COUNT_W'(1);
                  end else if ((fsub == SUB_DEAUTH) || (fsub == SUB_DISASSOC)) begin
                    cnt_deauth_d = cnt_deauth_q + COUNT_W'(1);
                  end
                end else if (ftype == FTYPE_DATA) begin
                  cnt_data_d = cnt_data_q + COUNT_W'(1);
                end
              end
            end
            OP_TICK: begin
              if (running_q) begin
                if (close_now) begin
                  elapsed_d     = '0;
                  sum_total_d   = sum_total_q + cnt_total_q;
                  sum_deauth_d  = sum_deauth_q + cnt_deauth_q;
                  ring_cmd.push = 1'b1;
                  ring_done_d   = 1'b0;
                  lane_d        = LANE_TOTAL;
                  div_start     = 1'b1;
                  state_d       = S_DIV;
                end else begin
                  elapsed_d = elapsed_inc;
                end
              end
            end
            OP_START: begin
              cnt_total_d    = '0;
              cnt_beacon_d   = '0;
              cnt_data_d     = '0;
              cnt_deauth_d   = '0;
              cnt_probe_d    = '0;
              cnt_mgmt_d     = '0;
              sum_total_d    = '0;
              sum_deauth_d   = '0;
              elapsed_d      = '0;
              ring_cmd.clear = 1'b1;
              running_d      = 1'b1;
            end
            OP_STOP: begin
              running_d = 1'b0;
            end
            default: begin
              running_d = running_q;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          rate_d[lane_q] = div_quot;
          if (lane_q == LANE_DEAUTH) begin
            state_d = S_JOIN;
          end else begin
            lane_d    = lane_q + 2'd1;
            div_start = 1'b1;
          end
        end
      end
      S_JOIN: begin
        // wait for the ring rescan and a free result register
        if (ring_done_q && out_free) begin
          load_out     = 1'b1;
          out_valid_d  = 1'b1;
          cnt_total_d  = '0;
          cnt_beacon_d = '0;
          cnt_data_d   = '0;
          cnt_deauth_d = '0;
          cnt_probe_d  = '0;
          cnt_mgmt_d   = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      period_q     <= PERIOD_RESET;
      running_q    <= 1'b0;
      elapsed_q    <= '0;
      cnt_total_q  <= '0;
      cnt_beacon_q <= '0;
      cnt_data_q   <= '0;
      cnt_deauth_q <= '0;
      cnt_probe_q  <= '0;
      cnt_mgmt_q   <= '0;
      sum_total_q  <= '0;
      sum_deauth_q <= '0;
      lane_q       <= LANE_TOTAL;
      ring_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      period_q     <= period_d;
      running_q    <= running_d;
      elapsed_q    <= elapsed_d;
      cnt_total_q  <= cnt_total_d;
      cnt_beacon_q <= cnt_beacon_d;
      cnt_data_q   <= cnt_data_d;
      cnt_deauth_q <= cnt_deauth_d;
      cnt_probe_q  <= cnt_probe_d;
      cnt_mgmt_q   <= cnt_mgmt_d;
      sum_total_q  <= sum_total_d;
      sum_deauth_q <= sum_deauth_d;
      lane_q       <= lane_d;
      ring_done_q  <= ring_done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_d;
    if (load_out) begin
      o_rate_total_q  <= rate_q[LANE_TOTAL];
      o_rate_beacon_q <= rate_q[LANE_BEACON];
      o_rate_data_q   <= rate_q[LANE_DATA];
      o_rate_deauth_q <= rate_q[LANE_DEAUTH];
      o_probe_q       <= cnt_probe_q;
      o_mgmt_q        <= cnt_mgmt_q;
      o_peak_q        <= ring_stat.peak;
      o_sum_total_q   <= sum_total_q;
      o_sum_deauth_q  <= sum_deauth_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign rate_total_o      = o_rate_total_q;
  assign rate_beacon_o     = o_rate_beacon_q;
  assign rate_data_o       = o_rate_data_q;
  assign rate_deauth_o     = o_rate_deauth_q;
  assign window_probe_o    = o_probe_q;
  assign window_mgmt_o     = o_mgmt_q;
  assign history_max_o     = o_peak_q;
  assign all_time_total_o  = o_sum_total_q;
  assign all_time_deauth_o = o_sum_deauth_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the rate phase");

  a_ring_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_stat.done |-> (state_q != S_IDLE))
    else $error("ring rescan finished while no window close is pending");

  a_close_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_now |=> !in_ready_o)
    else $error("input still taken after a window close");

  a_peak_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (history_max_o != '0))
    else $error("history maximum below one in a result");
`endif

endmodule
